// ===== hdl/actr_pkg.sv =====
`timescale 1ns / 1ps
package actr_pkg;

  localparam int unsigned KeyIdxW = 1;
  localparam logic KeyUpperIdx = 1'b0;
  localparam logic KeyLowerIdx = 1'b1;
  localparam int unsigned NumRounds = 10;

  // classified job passed from front to back
  typedef struct packed {
    logic [127:0] ctr_blk;
    logic [127:0] text;
    logic [15:0]  byte_mask;
    logic [4:0]   count;
    logic         last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last_rnd);
    logic [7:0] n [16];
    logic [7:0] m [16];
    logic [7:0] t;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        n[c*4+i] = SBOX[s[127-8*(((c+i)%4)*4+i) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      t = n[c*4] ^ n[c*4+1] ^ n[c*4+2] ^ n[c*4+3];
      m[c*4]   = n[c*4]   ^ t ^ xt(n[c*4]   ^ n[c*4+1]);
      m[c*4+1] = n[c*4+1] ^ t ^ xt(n[c*4+1] ^ n[c*4+2]);
      m[c*4+2] = n[c*4+2] ^ t ^ xt(n[c*4+2] ^ n[c*4+3]);
      m[c*4+3] = n[c*4+3] ^ t ^ xt(n[c*4+3] ^ n[c*4]);
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = (last_rnd ? n[i] : m[i]) ^ rk[127-8*i -: 8];
    end
    enc_round = r;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_rkey = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== hdl/aes128_ctr_decrypt_core.sv =====
`timescale 1ns / 1ps
// aes-128 counter mode decryption, one round per cycle in a single shared round unit
// a request passes the queue, then 10 rounds, the last one going into the output register
// one data block in the round loop at a time; its last round waits on a full, stalled output
// iv blocks are absorbed in the front and produce no result
// reset (async, active low): key zero, nonce/counter zero, no iv loaded, queue empty
module aes128_ctr_decrypt_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,   // data_upper, data_lower, byte_count, pad
  input  logic          s_axis_tuser,   // is_iv
  input  logic          s_axis_tlast,   // last_block
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // text_upper, text_lower, valid_bytes, pad
  output logic          m_axis_tlast    // end_of_message
);
  // key registers; round keys are derived on the fly in the back end
  logic [63:0] key_up_q, key_lo_q;
  logic        job_valid, job_ready;
  actr_pkg::job_t job;
  logic [133:0] out_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_up_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        actr_pkg::KeyUpperIdx: key_up_q <= cfg_data_i;
        actr_pkg::KeyLowerIdx: key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: iv capture, counter tracking, request queue
  actr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .data_i       ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .byte_count_i (s_axis_tdata[132:128]),
    .is_iv_i      (s_axis_tuser),
    .last_block_i (s_axis_tlast),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job)
  );

  // back: iterative aes rounds and output register
  actr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_up_q, key_lo_q}),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_raw)
  );

  // back packs {last, count, lower, upper}
  assign m_axis_tdata = {3'b000, out_raw[132:0]};
  assign m_axis_tlast = out_raw[133];
endmodule

// ===== hdl/actr_front.sv =====
`timescale 1ns / 1ps
module actr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [127:0]        data_i,
  input  logic [4:0]          byte_count_i,
  input  logic                is_iv_i,
  input  logic                last_block_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output actr_pkg::job_t      job_o
);
  logic [63:0] nonce_q, nonce_d, ctr_q, ctr_d;
  logic        loaded_q, loaded_d;
  // two-entry queue
  actr_pkg::job_t fifo_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  logic [4:0]  cnt_sat;
  actr_pkg::job_t new_job;
  logic        acc;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign acc         = in_valid_i && in_ready_o;
  assign cnt_sat     = byte_count_i[4] ? 5'd16 : byte_count_i;
  assign push        = acc && !is_iv_i && loaded_q && (cnt_sat != 5'd0);
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rptr_q];

  always_comb begin
    new_job.ctr_blk = {nonce_q, ctr_q};
    new_job.text    = data_i;
    new_job.count   = cnt_sat;
    new_job.last    = last_block_i;
    for (int i = 0; i < 16; i++) begin
      new_job.byte_mask[15-i] = (5'(i) < cnt_sat);
    end
  end

  always_comb begin
    nonce_d  = nonce_q;
    ctr_d    = ctr_q;
    loaded_d = loaded_q;
    if (acc) begin
      if (is_iv_i) begin
        nonce_d  = data_i[127:64];
        ctr_d    = data_i[63:0];
        loaded_d = 1'b1;
      end else if (loaded_q) begin
        if (cnt_sat != 5'd0) ctr_d = ctr_q + 64'd1;
        if (last_block_i) loaded_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonce_q  <= '0;
      ctr_q    <= '0;
      loaded_q <= 1'b0;
      wptr_q   <= 1'b0;
      rptr_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      nonce_q  <= nonce_d;
      ctr_q    <= ctr_d;
      loaded_q <= loaded_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= new_job;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
  a_iv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_iv_i) |=> loaded_q) else $error("iv not loaded");
`endif
endmodule

// ===== hdl/actr_back.sv =====
`timescale 1ns / 1ps
module actr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [127:0]        key_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  actr_pkg::job_t      job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [133:0]        out_data_o
);
  logic          busy_q;
  logic [3:0]    rnd_q;
  logic [127:0]  st_q, rk_q, txt_q;
  logic [15:0]   mask_q;
  logic [4:0]    count_q;
  logic          last_q;
  logic          oval_q;
  logic [127:0]  otext_q;
  logic [4:0]    ocount_q;
  logic          olast_q;
  logic [127:0]  rk_nxt, st_nxt, ks_x;
  logic          done, start;

  assign rk_nxt = actr_pkg::next_rkey(rk_q, actr_pkg::RCON[rnd_q - 4'd1]);
  assign st_nxt = actr_pkg::enc_round(st_q, rk_nxt, rnd_q == 4'(actr_pkg::NumRounds));
  assign done   = busy_q && (rnd_q == 4'(actr_pkg::NumRounds)) && (!oval_q || out_ready_i);
  assign job_ready_o = !busy_q;
  assign start  = job_valid_i && !busy_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_x[127-8*i -: 8] = mask_q[15-i] ? (st_nxt[127-8*i -: 8] ^ txt_q[127-8*i -: 8]) : 8'h00;
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = {olast_q, ocount_q,
                        otext_q[63:56], otext_q[55:48], otext_q[47:40], otext_q[39:32],
                        otext_q[31:24], otext_q[23:16], otext_q[15:8], otext_q[7:0],
                        otext_q[127:64]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      if (done) begin
        oval_q <= 1'b1;
      end else if (out_ready_i) begin
        oval_q <= 1'b0;
      end
      if (start) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (busy_q && rnd_q != 4'(actr_pkg::NumRounds)) begin
        rnd_q <= rnd_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      st_q    <= job_i.ctr_blk ^ key_i;
      rk_q    <= key_i;
      txt_q   <= job_i.text;
      mask_q  <= job_i.byte_mask;
      count_q <= job_i.count;
      last_q  <= job_i.last;
    end else if (busy_q && rnd_q != 4'(actr_pkg::NumRounds)) begin
      st_q <= st_nxt;
      rk_q <= rk_nxt;
    end
    if (done) begin
      otext_q  <= ks_x;
      ocount_q <= count_q;
      olast_q  <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rnd_q >= 4'd1 && rnd_q <= 4'd10)) else $error("round out of range");
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> oval_q) else $error("result lost");
  a_cnt_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oval_q |-> (ocount_q != 5'd0 && ocount_q <= 5'd16)) else $error("bad count");
`endif
endmodule
